>>> rtl/lsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants
// Fixed-point constants and the divider request/response structs.
// ----------------------------------------------------------------------------
package lsr_pkg;

    // fraction bits of Q16.16 fixed point
    localparam int QBITS = 16;

    // divider operand width (covers up to |2*dv|*2^16, 33+17 bits)
    localparam int DW = 52;

    // divider request: signed dividend over a positive divisor
    typedef struct packed {
        logic          start;
        logic          neg;     // quotient sign
        logic [DW-1:0] num;     // magnitude of dividend
        logic [DW-1:0] den;     // magnitude of divisor, nonzero
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quo;     // magnitude, truncated
        logic          neg;
    } div_rsp_t;

endpackage

>>> rtl/lsr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsr_divider: shared restoring divider
// One quotient bit per cycle, unsigned magnitudes, sign applied by the user.
// ----------------------------------------------------------------------------
module lsr_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  lsr_pkg::div_req_t req,
    output lsr_pkg::div_rsp_t rsp
);

    localparam int W  = lsr_pkg::DW;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          neg_reg;
    logic [W:0]    trial;

    // shift one dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                quo_reg  <= req.num;
                rem_reg  <= '0;
                den_reg  <= req.den;
                neg_reg  <= req.neg;
            end
            else if (busy_reg)
            begin
                if (!trial[W])
                begin
                    rem_reg <= trial[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.neg  = neg_reg;

endmodule

>>> rtl/limited_slope_reconstruction_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limited_slope_reconstruction_core: MUSCL slopes with minbee limiter
// Three-cell window over a streamed mesh; inner cell slopes from one shared
// divider and one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// channel  dir  handshake          contents
// s_axis   in   tvalid/tready      tdata: cell nodes and means, tlast: last cell
// m_axis   out  tvalid/tready      tdata: means and slopes, tlast: final result
//
// An inner cell runs 2*VARIABLE_COUNT+2 divisions (each issued, loaded, run
// for its 52 quotient bits and marked done) plus 3*VARIABLE_COUNT multiply
// steps; a zero limiter skips the last two divisions and the multiply steps.
// Boundary cells and degenerate spacing skip the divider.
// s_axis_tready is low while a cell is worked on or a result waits; a last
// cell behind held cells sends a second word once the first is taken.
// Reset empties the window; a stalled m_axis holds its word.
// ----------------------------------------------------------------------------
module limited_slope_reconstruction_core
#(
    parameter int VARIABLE_COUNT = 3
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // left_node, right_node, value_0 .. value_{N-1}
    input  logic [32*(VARIABLE_COUNT+2)-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // mean_0 .. mean_{N-1}, slope_0 .. slope_{N-1}
    output logic [64*VARIABLE_COUNT-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast
);

    localparam int N  = VARIABLE_COUNT;
    localparam int VW = (N > 1) ? $clog2(N) : 1;
    localparam int W  = lsr_pkg::DW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GL    = 4'd1;  // divide for gL[j]
    localparam logic [3:0] S_GR    = 4'd2;  // divide for gR[j]
    localparam logic [3:0] S_PHI   = 4'd3;  // limiter divide
    localparam logic [3:0] S_WL    = 4'd4;  // weight divide
    localparam logic [3:0] S_M1    = 4'd5;  // wl*gL
    localparam logic [3:0] S_M2    = 4'd6;  // + wr*gR, >>16
    localparam logic [3:0] S_M3    = 4'd7;  // phi*c, >>16, sat
    localparam logic [3:0] S_OUT1  = 4'd8;  // emit inner or boundary result
    localparam logic [3:0] S_OUT2  = 4'd9;  // emit last-cell result
    localparam logic [3:0] S_WAIT  = 4'd10; // wait for divider

    logic [3:0]  state_reg, ret_reg;
    logic [1:0]  seen_reg;
    logic [31:0] vold_reg [N];
    logic [31:0] vmid_reg [N];
    logic [31:0] vcur_reg [N];
    logic [31:0] nold_reg, nmidl_reg, nmidr_reg, curl_reg, curr_reg;
    logic        last_reg;
    logic [31:0] gl_reg [N];
    logic [31:0] gr_reg [N];
    logic [31:0] sl_reg [N];
    logic [16:0] phi_reg, wl_reg;
    logic [VW-1:0] idx_reg;
    logic signed [80:0] acc_reg;
    logic        ovalid_reg, otlast_reg;
    logic [64*N-1:0] odata_reg;

    lsr_pkg::div_req_t dreq;
    lsr_pkg::div_rsp_t drsp;

    lsr_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // spacings
    logic signed [32:0] dl, dr;
    assign dl = $signed({nmidr_reg[31], nmidr_reg}) - $signed({nold_reg[31], nold_reg});
    assign dr = $signed({curr_reg[31], curr_reg}) - $signed({nmidl_reg[31], nmidl_reg});

    // signed divider result with 32-bit saturation
    logic signed [W:0] qs;
    logic [31:0]       qsat;
    assign qs   = drsp.neg ? -$signed({1'b0, drsp.quo}) : $signed({1'b0, drsp.quo});
    assign qsat = (qs > $signed((W+1)'(32'h7FFFFFFF))) ? 32'h7FFFFFFF :
                  (qs < -$signed((W+1)'(33'h080000000))) ? 32'h80000000 : qs[31:0];

    // value difference for gL/gR, times 2^17
    logic signed [32:0] dv;
    logic [W-1:0]       dvmag;
    always_comb
    begin
        if (state_reg == S_GL)
            dv = $signed({vmid_reg[idx_reg][31], vmid_reg[idx_reg]})
               - $signed({vold_reg[idx_reg][31], vold_reg[idx_reg]});
        else
            dv = $signed({vcur_reg[idx_reg][31], vcur_reg[idx_reg]})
               - $signed({vmid_reg[idx_reg][31], vmid_reg[idx_reg]});
    end
    assign dvmag = W'(dv[32] ? -dv : dv) << (lsr_pkg::QBITS + 1);

    // limiter operands from the last variable
    logic [31:0] ga, gb;
    logic        lim_zero;
    assign ga = gl_reg[N-1][31] ? -gl_reg[N-1] : gl_reg[N-1];
    assign gb = gr_reg[N-1][31] ? -gr_reg[N-1] : gr_reg[N-1];
    assign lim_zero = (gl_reg[N-1] == '0) || (gr_reg[N-1] == '0)
                   || (gl_reg[N-1][31] != gr_reg[N-1][31]);

    // shared multiplier: 33x33 signed
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    always_comb
    begin
        case (state_reg)
            S_M1:    begin ma = $signed({16'd0, wl_reg}); mb = $signed({gl_reg[idx_reg][31], gl_reg[idx_reg]}); end
            S_M2:    begin ma = $signed(33'(18'h10000 - {1'b0, wl_reg})); mb = $signed({gr_reg[idx_reg][31], gr_reg[idx_reg]}); end
            default: begin ma = $signed({16'd0, phi_reg}); mb = $signed(acc_reg[32:0]); end
        endcase
    end
    assign prod = ma * mb;

    // truncating >>16 toward zero
    function automatic logic signed [80:0] tdiv16(input logic signed [80:0] x);
        logic signed [80:0] b;
        begin
            b = x + (x[80] ? 81'sd65535 : 81'sd0);
            return b >>> 16;
        end
    endfunction

    logic signed [80:0] msum, mres;
    assign msum = acc_reg + 81'(prod);
    assign mres = tdiv16(81'(prod));

    logic in_fire;
    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            seen_reg   <= '0;
            ovalid_reg <= 1'b0;
            otlast_reg <= 1'b0;
            idx_reg    <= '0;
            dreq.start <= 1'b0;
        end
        else
        begin
            dreq.start <= 1'b0;
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        curl_reg <= s_axis_tdata[31:0];
                        curr_reg <= s_axis_tdata[63:32];
                        for (int j = 0; j < N; j++)
                        begin
                            vcur_reg[j] <= s_axis_tdata[64+32*j +: 32];
                            sl_reg[j]   <= '0;
                        end
                        last_reg <= s_axis_tlast;
                        idx_reg  <= '0;
                        if (seen_reg == 2'd0)
                            state_reg <= s_axis_tlast ? S_OUT2 : S_OUT1;
                        else if (seen_reg == 2'd1)
                            state_reg <= S_OUT1;
                        else
                            state_reg <= S_GL;
                    end
                end
                S_GL, S_GR:
                begin
                    if (dl <= 0 || dr <= 0)
                        state_reg <= S_OUT1;
                    else
                    begin
                        dreq.start <= 1'b1;
                        dreq.neg   <= dv[32];
                        dreq.num   <= dvmag;
                        dreq.den   <= W'(state_reg == S_GL ? dl : dr);
                        ret_reg    <= state_reg;
                        state_reg  <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (drsp.done)
                    begin
                        case (ret_reg)
                            S_GL:
                            begin
                                gl_reg[idx_reg] <= qsat;
                                state_reg <= S_GR;
                            end
                            S_GR:
                            begin
                                gr_reg[idx_reg] <= qsat;
                                if (idx_reg == VW'(N - 1))
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= S_PHI;
                                end
                                else
                                begin
                                    idx_reg   <= idx_reg + 1'b1;
                                    state_reg <= S_GL;
                                end
                            end
                            S_PHI:
                            begin
                                phi_reg   <= qsat[16:0];
                                state_reg <= S_WL;
                            end
                            default:
                            begin
                                wl_reg    <= qsat[16:0];
                                state_reg <= S_M1;
                            end
                        endcase
                    end
                end
                S_PHI:
                begin
                    if (lim_zero)
                        state_reg <= S_OUT1;
                    else
                    begin
                        dreq.start <= 1'b1;
                        dreq.neg   <= 1'b0;
                        if (ga <= gb)
                        begin
                            dreq.num <= W'(ga) << lsr_pkg::QBITS;
                            dreq.den <= W'(gb);
                        end
                        else
                        begin
                            dreq.num <= W'(gb) << (lsr_pkg::QBITS + 1);
                            dreq.den <= W'(ga) + W'(gb);
                        end
                        ret_reg   <= S_PHI;
                        state_reg <= S_WAIT;
                    end
                end
                S_WL:
                begin
                    dreq.start <= 1'b1;
                    dreq.neg   <= 1'b0;
                    dreq.num   <= W'(dr) << lsr_pkg::QBITS;
                    dreq.den   <= W'(dl) + W'(dr);
                    ret_reg    <= S_WL;
                    state_reg  <= S_WAIT;
                end
                S_M1:
                begin
                    acc_reg   <= 81'(prod);
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    acc_reg   <= tdiv16(msum);
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    if (mres > 81'sd2147483647)
                        sl_reg[idx_reg] <= 32'h7FFFFFFF;
                    else if (mres < -81'sd2147483648)
                        sl_reg[idx_reg] <= 32'h80000000;
                    else
                        sl_reg[idx_reg] <= mres[31:0];
                    if (idx_reg == VW'(N - 1))
                        state_reg <= S_OUT1;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_M1;
                    end
                end
                S_OUT1:
                begin
                    if (!ovalid_reg)
                    begin
                        for (int j = 0; j < N; j++)
                        begin
                            odata_reg[32*j +: 32]     <= vmid_reg[j];
                            odata_reg[32*(N+j) +: 32] <= sl_reg[j];
                        end
                        otlast_reg <= 1'b0;
                        ovalid_reg <= (seen_reg != 2'd0);
                        if (last_reg)
                            state_reg <= S_OUT2;
                        else
                        begin
                            for (int j = 0; j < N; j++)
                            begin
                                vold_reg[j] <= vmid_reg[j];
                                vmid_reg[j] <= vcur_reg[j];
                            end
                            nold_reg  <= nmidl_reg;
                            nmidl_reg <= curl_reg;
                            nmidr_reg <= curr_reg;
                            seen_reg  <= (seen_reg == 2'd0) ? 2'd1 : 2'd2;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_OUT2:
                begin
                    if (!ovalid_reg)
                    begin
                        for (int j = 0; j < N; j++)
                        begin
                            odata_reg[32*j +: 32]     <= vcur_reg[j];
                            odata_reg[32*(N+j) +: 32] <= '0;
                            vold_reg[j] <= '0;
                            vmid_reg[j] <= '0;
                        end
                        nold_reg   <= '0;
                        nmidl_reg  <= '0;
                        nmidr_reg  <= '0;
                        otlast_reg <= 1'b1;
                        ovalid_reg <= 1'b1;
                        seen_reg   <= '0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = otlast_reg;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for limited_slope_reconstruction_core
// Streams mesh sweeps into the core: a directed table (boundary cells,
// extremes, ramp, limiter, saturation, degenerate spacing), then random sweeps.
// Words are checked against a local slope predictor, or for typed cells
// against the cell itself; random idling on either side in later random phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NV          = 3;
    localparam int Q_ONE       = 65536;
    localparam int WDOG_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 600;
    localparam int RAND_ITEMS  = 700;

    typedef struct {
        logic signed [31:0] left_node;
        logic signed [31:0] right_node;
        logic signed [31:0] value [NV];
        logic               sweep_end;
        logic               typed;      // expected word written in the table
    } cell_t;

    typedef struct {
        logic signed [31:0] mean  [NV];
        logic signed [31:0] slope [NV];
        logic               final_result;
    } recon_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // left_node, right_node, value_0 .. value_2
    logic [32*(NV+2)-1:0] s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // mean_0 .. mean_2, slope_0 .. slope_2
    logic [64*NV-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;

    // predictor window
    logic signed [31:0] win_vals  [2*NV];
    logic signed [31:0] win_nodes [3];
    logic [1:0]         held_cells;

    recon_t  recon_q [$];
    int      fail_cnt;
    int      idle_pct;
    int      stall_pct;
    int      quiet_cycles;

    limited_slope_reconstruction_core #(.VARIABLE_COUNT(NV)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint sat32(longint v);
        if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -longint'(64'sh80000000)) return -longint'(64'sh80000000);
        return v;
    endfunction

    function automatic longint minbee(longint gl, longint gr);
        longint a;
        longint b;
        if (gl == 0 || gr == 0) return 0;
        if ((gl < 0) != (gr < 0)) return 0;
        a = gl < 0 ? -gl : gl;
        b = gr < 0 ? -gr : gr;
        if (a <= b) return a * Q_ONE / b;
        return 2 * b * Q_ONE / (a + b);
    endfunction

    function automatic void clear_window();
        for (int j = 0; j < 2*NV; j++) win_vals[j] = '0;
        for (int j = 0; j < 3; j++) win_nodes[j] = '0;
        held_cells = '0;
    endfunction

    // limited slopes of the newer held cell, given the incoming cell
    function automatic void limited_slopes(cell_t c, output logic signed [31:0] s [NV]);
        longint dl;
        longint dr;
        longint gl [NV];
        longint gr [NV];
        longint phi;
        longint wl;
        longint wr;
        longint ctr;
        dl = longint'(win_nodes[2]) - longint'(win_nodes[0]);
        dr = longint'(c.right_node) - longint'(win_nodes[1]);
        for (int j = 0; j < NV; j++) s[j] = '0;
        if (dl <= 0 || dr <= 0) return;
        for (int j = 0; j < NV; j++)
        begin
            gl[j] = sat32((longint'(win_vals[NV+j]) - longint'(win_vals[j])) * 2 * Q_ONE / dl);
            gr[j] = sat32((longint'(c.value[j]) - longint'(win_vals[NV+j])) * 2 * Q_ONE / dr);
        end
        phi = minbee(gl[NV-1], gr[NV-1]);
        wl  = dr * Q_ONE / (dl + dr);
        wr  = Q_ONE - wl;
        for (int j = 0; j < NV; j++)
        begin
            ctr  = (wl * gl[j] + wr * gr[j]) / Q_ONE;
            s[j] = 32'(sat32(phi * ctr / Q_ONE));
        end
    endfunction

    // advance the window by one accepted cell, queueing the words it causes
    function automatic void predict_cell(cell_t c, bit push);
        recon_t r;
        if (held_cells != 0)
        begin
            for (int j = 0; j < NV; j++) r.mean[j] = win_vals[NV+j];
            if (held_cells == 1)
                for (int j = 0; j < NV; j++) r.slope[j] = '0;
            else
                limited_slopes(c, r.slope);
            r.final_result = 1'b0;
            if (push) recon_q.push_back(r);
        end
        if (c.sweep_end)
        begin
            for (int j = 0; j < NV; j++)
            begin
                r.mean[j]  = c.value[j];
                r.slope[j] = '0;
            end
            r.final_result = 1'b1;
            if (push) recon_q.push_back(r);
            clear_window();
            return;
        end
        for (int j = 0; j < NV; j++)
        begin
            win_vals[j]    = win_vals[NV+j];
            win_vals[NV+j] = c.value[j];
        end
        win_nodes[0] = win_nodes[1];
        win_nodes[1] = c.left_node;
        win_nodes[2] = c.right_node;
        held_cells   = (held_cells == 0) ? 2'd1 : 2'd2;
    endfunction

    // drive one cell word and wait for it to be taken
    task automatic send_cell(cell_t c);
        recon_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c.value[2], c.value[1], c.value[0], c.right_node, c.left_node};
        s_axis_tlast  <= c.sweep_end;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        // single-cell sweep from an empty window: word read off directly
        if (c.typed)
        begin
            for (int j = 0; j < NV; j++)
            begin
                r.mean[j]  = c.value[j];
                r.slope[j] = '0;
            end
            r.final_result = 1'b1;
            recon_q.push_back(r);
        end
        predict_cell(c, !c.typed);
    endtask

    function automatic cell_t mk(int l, int r, int a, int b, int d, bit last, bit typed);
        cell_t c;
        c.left_node  = l;
        c.right_node = r;
        c.value[0]   = a;
        c.value[1]   = b;
        c.value[2]   = d;
        c.sweep_end  = last;
        c.typed      = typed;
        return c;
    endfunction

    // one random sweep: mostly well-formed meshes, some noise
    task automatic random_sweep(output int n);
        cell_t c;
        int    pos;
        int    w;
        int    base [NV];
        int    kind;
        n    = $urandom_range(7, 1);
        kind = $urandom_range(9);
        pos  = int'($urandom) >>> 4;
        for (int j = 0; j < NV; j++) base[j] = int'($urandom) >>> 8;
        for (int i = 0; i < n; i++)
        begin
            w = (kind == 0) ? int'($urandom_range(3)) - 1 : int'($urandom_range(1 << 18, 1));
            c.left_node  = pos;
            c.right_node = pos + w;
            pos = pos + w;
            for (int j = 0; j < NV; j++)
            begin
                if (kind == 1)
                    c.value[j] = int'($urandom);
                else
                begin
                    base[j] = base[j] + int'($urandom_range(1 << 17)) - (1 << 16);
                    c.value[j] = base[j];
                end
            end
            if (kind == 2)
            begin
                c.left_node  = int'($urandom);
                c.right_node = int'($urandom);
            end
            if (kind == 3 && $urandom_range(1)) c.value[NV-1] = base[NV-1] - 1;
            c.sweep_end = (i == n - 1);
            c.typed     = 1'b0;
            send_cell(c);
        end
    endtask

    // receiver stalls, output check and watchdog
    always @(posedge clk)
    begin
        recon_t e;
        logic signed [31:0] got;
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (recon_q.size() == 0)
                begin
                    $error("unexpected word: %h", m_axis_tdata);
                    fail_cnt++;
                end
                else
                begin
                    e = recon_q.pop_front();
                    for (int j = 0; j < NV; j++)
                    begin
                        got = m_axis_tdata[32*j +: 32];
                        if (got !== e.mean[j])
                        begin
                            $error("mean_%0d: expected %0d, actual %0d", j, e.mean[j], got);
                            fail_cnt++;
                        end
                        got = m_axis_tdata[32*(NV+j) +: 32];
                        if (got !== e.slope[j])
                        begin
                            $error("slope_%0d: expected %0d, actual %0d", j, e.slope[j], got);
                            fail_cnt++;
                        end
                    end
                    if (m_axis_tlast !== e.final_result)
                    begin
                        $error("final_result: expected %0d, actual %0d",
                               e.final_result, m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (quiet_cycles >= WDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        cell_t dir_tab [$];
        int    sent;
        int    n;
        bit    paused;
        fail_cnt      = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        quiet_cycles  = 0;
        paused        = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        clear_window();

        // single-cell sweeps at the extremes
        dir_tab.push_back(mk(0, 0, 0, 0, 0, 1, 1));
        dir_tab.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 1, 1));
        dir_tab.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 1, 1));
        // smooth ramp, equal spacing
        dir_tab.push_back(mk(0, 65536, 0, 100, 65536, 0, 0));
        dir_tab.push_back(mk(65536, 131072, 65536, 300, 196608, 0, 0));
        dir_tab.push_back(mk(131072, 196608, 131072, 700, 262144, 0, 0));
        dir_tab.push_back(mk(196608, 262144, 196608, 900, 524288, 1, 0));
        // limiter sign change and zero derivative
        dir_tab.push_back(mk(0, 1000, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(1000, 2000, 5000, 5000, 5000, 0, 0));
        dir_tab.push_back(mk(2000, 3000, 100, 100, 100, 0, 0));
        dir_tab.push_back(mk(3000, 4000, 100, 9, 100, 1, 0));
        // degenerate spacing: zero and inverted cells
        dir_tab.push_back(mk(10, 10, 1, 2, 3, 0, 0));
        dir_tab.push_back(mk(10, 5, 7, 8, 9, 0, 0));
        dir_tab.push_back(mk(5, 20, -1, -2, -3, 1, 0));
        // saturation: full-range swings over tiny spacing
        dir_tab.push_back(mk(0, 1, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0));
        dir_tab.push_back(mk(1, 2, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(2, 3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 0));
        // node extremes, unequal spacing
        dir_tab.push_back(mk(32'h80000000, 32'h80000001, 10, -10, 1000, 0, 0));
        dir_tab.push_back(mk(0, 4, 20, -30, 2000, 0, 0));
        dir_tab.push_back(mk(4, 32'h7fffffff, 30, -50, 2001, 1, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i]) send_cell(dir_tab[i]);

        // random sweeps through the idling phases
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            case (sent * 4 / RAND_ITEMS)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            if (!paused && sent > RAND_ITEMS / 2)
            begin
                // hold off until the core has drained
                paused = 1;
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (recon_q.size() != 0) @(posedge clk);
            end
            random_sweep(n);
            sent += n;
        end
        s_axis_tvalid <= 1'b0;

        while (recon_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_cnt == 0 && recon_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
